[src/sha256_pkg.sv]
// Package: SHA-256 constants, sequencer state type and round functions.
package sha256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int LEN_POS     = 56;
  localparam int ROUNDS      = 64;
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DATA,
    ST_MARK,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam logic [31:0] HASH_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

[src/sha256_stream_hasher_core.sv]
// SHA-256 stream hasher: byte packing, padding sequencer and iterative round unit.
// A message arrives one big-endian 32-bit word per beat, with a count of its valid
// leading bytes (counts above four act as four); the beat marked final may be partial
// or empty and closes the message. in_ready is high only while the sequencer is idle.
// A word beat is accepted while idle, then shifted into the 512-bit block register;
// a beat that straddles a block boundary finishes after that block is hashed. Each
// full 64-byte block then runs 64 rounds on the single shared round unit, started
// from the chaining state in the cycle that completes the block, and one fold
// into the chaining state. The round unit limits sustained throughput, since no word
// is taken while it runs. The final beat adds padding: the 0x80 byte, zero fill up
// to the length slot, the two 32-bit length words, the last block, and possibly one
// extra block when the length no longer fits. The 256-bit digest then sits in an
// output register until taken, while the next message may already stream in; the
// chaining state reloads the initial hash values when the digest is handed over.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_a,
  output logic [63:0] out_digest_b,
  output logic [63:0] out_digest_c,
  output logic [63:0] out_digest_d
);
  import sha256_pkg::*;

  state_t        state_r, state_nxt;
  state_t        ret_r, ret_nxt;
  logic [6:0]    fill_r, fill_nxt;
  logic [63:0]   bits_r, bits_nxt;
  logic [31:0]   chain_r [0:7];
  logic [31:0]   chain_nxt [0:7];
  logic [31:0]   work_r [0:7];
  logic [31:0]   work_nxt [0:7];
  logic [511:0]  block_r, block_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic [2:0]    pend_cnt_r, pend_cnt_nxt;
  logic          final_r, final_nxt;
  logic [5:0]    rnd_r, rnd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [255:0]  digest_r, digest_nxt;

  // push engine
  logic          pushing;
  logic [2:0]    push_k;
  logic [31:0]   push_src;
  logic [6:0]    room;
  logic [6:0]    zero_target;
  logic [6:0]    zero_gap;
  logic [6:0]    fill_sum;
  logic          hit_full;
  state_t        follow;
  logic [511:0]  block_push;
  logic [31:0]   pend_shift;
  logic [2:0]    in_cnt;
  logic          out_load;

  // round unit
  logic [31:0]   w_cur;
  logic [31:0]   w_new;
  logic [31:0]   t1;
  logic [31:0]   t2;

  assign in_cnt   = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
  assign room     = 7'(BLOCK_BYTES) - fill_r;
  assign zero_target = (fill_r < 7'(LEN_POS)) ? 7'(LEN_POS) : 7'(BLOCK_BYTES);
  assign zero_gap = zero_target - fill_r;
  assign fill_sum = fill_r + {4'b0000, push_k};
  assign hit_full = pushing && (fill_sum == 7'(BLOCK_BYTES));
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // byte source and count for the current packing step
  always_comb begin
    pushing  = 1'b0;
    push_k   = 3'd0;
    push_src = pend_r;
    follow   = state_r;
    unique case (state_r)
      ST_DATA: begin
        pushing = 1'b1;
        push_k  = ({4'b0000, pend_cnt_r} <= room) ? pend_cnt_r : room[2:0];
        if (push_k == pend_cnt_r) begin
          follow = final_r ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        pushing  = 1'b1;
        push_k   = 3'd1;
        push_src = {PAD_MARK, 24'h0};
        // skip the zero fill when the mark lands right before the length slot
        follow   = (fill_r == 7'(LEN_POS - 1)) ? ST_LEN_HI : ST_ZERO;
      end
      ST_ZERO: begin
        pushing  = 1'b1;
        push_k   = (zero_gap >= 7'd4) ? 3'd4 : zero_gap[2:0];
        push_src = 32'h0;
        follow   = ((fill_r < 7'(LEN_POS)) && (zero_gap <= 7'd4)) ? ST_LEN_HI : ST_ZERO;
      end
      ST_LEN_HI: begin
        pushing  = 1'b1;
        push_k   = 3'd4;
        push_src = bits_r[63:32];
        follow   = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        pushing  = 1'b1;
        push_k   = 3'd4;
        push_src = bits_r[31:0];
        follow   = ST_OUT;
      end
      default: begin
        pushing = 1'b0;
      end
    endcase
  end

  // shift accepted bytes into the block and out of the pending word
  always_comb begin
    case (push_k)
      3'd1: begin
        block_push = {block_r[503:0], push_src[31:24]};
        pend_shift = {pend_r[23:0], 8'h0};
      end
      3'd2: begin
        block_push = {block_r[495:0], push_src[31:16]};
        pend_shift = {pend_r[15:0], 16'h0};
      end
      3'd3: begin
        block_push = {block_r[487:0], push_src[31:8]};
        pend_shift = {pend_r[7:0], 24'h0};
      end
      3'd4: begin
        block_push = {block_r[479:0], push_src};
        pend_shift = 32'h0;
      end
      default: begin
        block_push = block_r;
        pend_shift = pend_r;
      end
    endcase
  end

  // schedule window: word 0 of the block is w[t], word 15 is w[t+15]
  assign w_cur = block_r[511:480];
  assign w_new = small_sigma1(block_r[63:32]) + block_r[223:192]
               + small_sigma0(block_r[479:448]) + block_r[511:480];
  assign t1 = work_r[7] + big_sigma1(work_r[4]) + choose(work_r[4], work_r[5], work_r[6])
            + ROUND_K[rnd_r] + w_cur;
  assign t2 = big_sigma0(work_r[0]) + majority(work_r[0], work_r[1], work_r[2]);

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA, ST_MARK, ST_ZERO, ST_LEN_HI, ST_LEN_LO: begin
        if (hit_full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = follow;
        end else begin
          state_nxt = follow;
        end
      end
      ST_ROUND: begin
        if (rnd_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    block_nxt     = block_r;
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    final_nxt     = final_r;
    rnd_nxt       = rnd_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int i = 0; i < 8; i++) begin
      chain_nxt[i] = chain_r[i];
      work_nxt[i]  = work_r[i];
    end

    if (in_valid && in_ready) begin
      pend_nxt     = in_message_word;
      pend_cnt_nxt = in_cnt;
      final_nxt    = in_final_item;
      bits_nxt     = bits_r + {58'h0, in_cnt, 3'b000};
    end

    if (pushing) begin
      block_nxt    = block_push;
      fill_nxt     = fill_sum;
      pend_nxt     = pend_shift;
      pend_cnt_nxt = pend_cnt_r - push_k;
    end

    // full block: start the rounds from the chaining state
    if (hit_full) begin
      fill_nxt = 7'd0;
      rnd_nxt  = 6'd0;
      for (int i = 0; i < 8; i++) begin
        work_nxt[i] = chain_r[i];
      end
    end

    if (state_r == ST_ROUND) begin
      block_nxt   = {block_r[479:0], w_new};
      rnd_nxt     = rnd_r + 6'd1;
      work_nxt[0] = t1 + t2;
      work_nxt[1] = work_r[0];
      work_nxt[2] = work_r[1];
      work_nxt[3] = work_r[2];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[5] = work_r[4];
      work_nxt[6] = work_r[5];
      work_nxt[7] = work_r[6];
    end

    if (state_r == ST_FOLD) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end

    // hand over the digest, then start a fresh message
    if (out_load) begin
      out_valid_nxt = 1'b1;
      digest_nxt    = {chain_r[0], chain_r[1], chain_r[2], chain_r[3],
                       chain_r[4], chain_r[5], chain_r[6], chain_r[7]};
      bits_nxt      = 64'h0;
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = HASH_INIT[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= 7'd0;
      bits_r      <= 64'h0;
      pend_cnt_r  <= 3'd0;
      final_r     <= 1'b0;
      rnd_r       <= 6'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= HASH_INIT[i];
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      final_r     <= final_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    block_r  <= block_nxt;
    pend_r   <= pend_nxt;
    digest_r <= digest_nxt;
    for (int i = 0; i < 8; i++) begin
      work_r[i] <= work_nxt[i];
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_digest_a = digest_r[255:192];
  assign out_digest_b = digest_r[191:128];
  assign out_digest_c = digest_r[127:64];
  assign out_digest_d = digest_r[63:0];

  a_fill_below_block: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < 7'(BLOCK_BYTES))
    else $error("block fill reached a full block outside the round sequence");

  a_rounds_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && (rnd_r == 6'(ROUNDS - 1)) |=> (state_r == ST_FOLD))
    else $error("round sequence did not end in fold");

  a_accept_to_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == ST_DATA))
    else $error("accepted beat not packed next");

  a_length_position: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEN_LO) |-> (fill_r == 7'(LEN_POS + 4)))
    else $error("low length word not at end of block");

  a_digest_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && out_valid_r && !out_ready |=> (state_r == ST_OUT))
    else $error("digest overwrote a result not yet taken");

endmodule
